[design/llsel_pkg.sv]
// llsel_pkg: shared types and constants for the least loaded selector
// used by llsel_alu and least_loaded_selector_top
package llsel_pkg;

    // fixed field widths of the stream and configuration payloads
    localparam int TARGET_W = 3;
    localparam int IDX_W    = 3;
    localparam int STATUS_W = 2;
    localparam int LOAD_W   = 11;
    localparam int ACT_W    = 4;
    localparam int ACT_RESET = 8;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;

    // item kinds carried on the input tuser bit
    localparam logic MODE_CHOOSE  = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RREAD,
        S_RDATA,
        S_UPDATE
    } state_t;

    // operations of the shared count unit
    typedef enum logic [1:0] {
        OP_PASS,
        OP_INC,
        OP_DEC
    } alu_op_t;

    // compare flags returned by the shared count unit
    typedef struct packed {
        logic below_cap;
        logic is_zero;
        logic better;
    } alu_flags_t;

endpackage

[design/least_loaded_selector_top.sv]
// least_loaded_selector_top: least loaded interface selector with an APB
// register port; uses llsel_pkg, llsel_alu and llsel_count_mem
//
// A choose item (s_tuser = 0) picks the active interface with the lowest busy
// count, lowest index on ties, stopping at the first zero count; counts at the
// cap are skipped. The count is incremented and the index returned. A release
// item (s_tuser = 1) decrements the count named in s_tdata. One result
// transfer leaves on the m_ side per input transfer, with status in m_tuser.
// Register 0 (address 0) holds the number of active interfaces, reset 8.
// A choose scans the counts through one memory read port, one entry a cycle,
// from index 0 through the active interfaces, ending early at a zero count;
// with no interface active it goes straight to the update step. A release
// reads its count through the same port, then updates it, and goes straight
// to the update step when its index is past the active set. s_tready returns
// when the sequencer is back in idle after the result is loaded. One item is
// in work at a time; s_tready is high only when idle.
// The result sits in an output register, so a new item is accepted while it
// waits; a finished item then holds in its update step until m_tready frees
// the output register. Reset clears all counts and empties the output.
module least_loaded_selector_top #(
    parameter int NUM_TARGETS = 8,
    parameter int LOAD_CAP    = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] target_index, rest zero
    input  logic        s_tuser,   // [0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] chosen_index, [13:3] load_after, rest zero
    output logic [1:0]  m_tuser,   // [1:0] status
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import llsel_pkg::*;

    localparam int AW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int NW = $clog2(NUM_TARGETS + 1);
    localparam int CW = $clog2(LOAD_CAP + 1);

    state_t              state_reg, state_next;
    logic [ACT_W-1:0]    active_reg, active_next;
    logic                mode_reg, mode_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic [NW-1:0]       issue_idx_reg, issue_idx_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic                found_reg, found_next;
    logic                bad_reg, bad_next;
    logic [AW-1:0]       best_idx_reg, best_idx_next;
    logic [CW-1:0]       best_cnt_reg, best_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [LOAD_W-1:0]   out_load_reg, out_load_next;

    logic                in_xfer;
    logic                cfg_wr;
    logic [NW-1:0]       n_eff;
    logic                issue_more;
    logic                hit_zero;
    logic                scan_done;
    logic                update_go;
    logic                rel_ok;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [CW-1:0]       rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [CW-1:0]       wr_data;
    alu_op_t             alu_op;
    logic [CW-1:0]       alu_a;
    logic [CW-1:0]       alu_res;
    alu_flags_t          alu_flags;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(active_reg) : '0;
    assign active_next = cfg_wr ? pwdata[ACT_W-1:0] : active_reg;

    // active count clipped to the storage depth
    assign n_eff = (32'(active_reg) > NUM_TARGETS) ? NW'(NUM_TARGETS) : NW'(active_reg);

    assign in_xfer    = s_tvalid && s_tready;
    assign issue_more = (issue_idx_reg < n_eff);
    assign hit_zero   = pend_reg && alu_flags.is_zero;
    assign scan_done  = hit_zero || (!pend_reg && !issue_more);
    assign update_go  = !out_valid_reg || m_tready;
    assign rel_ok     = !bad_reg && !alu_flags.is_zero;

    // shared count unit
    llsel_alu #(
        .CW       (CW),
        .LOAD_CAP (LOAD_CAP)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (best_cnt_reg),
        .found  (found_reg),
        .result (alu_res),
        .flags  (alu_flags)
    );

    // busy count store
    llsel_count_mem #(
        .DEPTH (NUM_TARGETS),
        .AW    (AW),
        .CW    (CW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_tuser == MODE_CHOOSE)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (32'(s_tdata[TARGET_W-1:0]) >= 32'(n_eff))
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        state_next = S_RREAD;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_RREAD:  state_next = S_RDATA;
            S_RDATA:  state_next = S_UPDATE;
            S_UPDATE:
            begin
                if (update_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        alu_op   = OP_PASS;
        alu_a    = best_cnt_reg;
        wr_en    = 1'b0;
        wr_addr  = best_idx_reg;
        wr_data  = alu_res;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_SCAN:
            begin
                alu_a   = rd_data;
                rd_en   = issue_more && !hit_zero;
                rd_addr = issue_idx_reg[AW-1:0];
            end
            S_RREAD:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(target_reg);
            end
            S_UPDATE:
            begin
                alu_op = (mode_reg == MODE_RELEASE) ? OP_DEC : OP_INC;
                if (mode_reg == MODE_RELEASE)
                begin
                    wr_addr = AW'(target_reg);
                    wr_en   = update_go && rel_ok;
                end
                else
                begin
                    wr_en = update_go && found_reg;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // item and scan datapath
    always_comb
    begin
        mode_next      = mode_reg;
        target_next    = target_reg;
        issue_idx_next = issue_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        bad_next       = bad_reg;
        best_idx_next  = best_idx_reg;
        best_cnt_next  = best_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    mode_next      = s_tuser;
                    target_next    = s_tdata[TARGET_W-1:0];
                    issue_idx_next = '0;
                    pend_next      = 1'b0;
                    found_next     = 1'b0;
                    best_cnt_next  = '0;
                    bad_next       = (32'(s_tdata[TARGET_W-1:0]) >= 32'(n_eff));
                end
            end
            S_SCAN:
            begin
                // evaluate the entry read last cycle
                if (pend_reg && alu_flags.below_cap
                    && (alu_flags.is_zero || alu_flags.better))
                begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_cnt_next = rd_data;
                end
                // issue the next read
                pend_next     = rd_en;
                pend_idx_next = rd_addr;
                if (rd_en)
                begin
                    issue_idx_next = issue_idx_reg + NW'(1);
                end
            end
            S_RDATA:
            begin
                best_cnt_next = rd_data;
            end
            default:
            begin
                found_next = found_reg;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        out_load_next   = out_load_reg;
        if ((state_reg == S_UPDATE) && update_go)
        begin
            out_valid_next = 1'b1;
            if (mode_reg == MODE_RELEASE)
            begin
                out_status_next = rel_ok ? ST_OK : ST_BAD_RELEASE;
                out_idx_next    = rel_ok ? IDX_W'(target_reg) : '0;
                out_load_next   = rel_ok ? LOAD_W'(alu_res) : '0;
            end
            else
            begin
                out_status_next = found_reg ? ST_OK : ST_NONE;
                out_idx_next    = found_reg ? IDX_W'(best_idx_reg) : '0;
                out_load_next   = found_reg ? LOAD_W'(alu_res) : '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= ACT_W'(ACT_RESET);
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        target_reg     <= target_next;
        issue_idx_reg  <= issue_idx_next;
        pend_idx_reg   <= pend_idx_next;
        found_reg      <= found_next;
        bad_reg        <= bad_next;
        best_idx_reg   <= best_idx_next;
        best_cnt_reg   <= best_cnt_next;
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
        out_load_reg   <= out_load_next;
    end

    // result ports
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_load_reg, out_idx_reg};

    // counts change only in the update step
    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_UPDATE))
        else $error("count write outside update step");

    // a pending scan read always names an active interface
    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && pend_reg) |-> (32'(pend_idx_reg) < 32'(n_eff)))
        else $error("scan read beyond active interfaces");

    // a chosen interface is below the cap
    a_best_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && mode_reg == MODE_CHOOSE && found_reg)
            |-> (32'(best_cnt_reg) < LOAD_CAP))
        else $error("chosen count at or above cap");

    // a finished update always loads the output register
    a_update_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && update_go) |=> out_valid_reg)
        else $error("update finished without a result");

    // a failed item reports zero index and load
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK)
            |-> (out_idx_reg == '0 && out_load_reg == '0))
        else $error("failed result carries index or load");

endmodule

[design/llsel_alu.sv]
// llsel_alu: shared count unit, compares a count against the cap, zero and the
// best so far, and forms the incremented or decremented count; uses llsel_pkg
module llsel_alu #(
    parameter int CW       = 11,
    parameter int LOAD_CAP = 1024
) (
    input  llsel_pkg::alu_op_t    op,
    input  logic [CW-1:0]         a,
    input  logic [CW-1:0]         b,
    input  logic                  found,
    output logic [CW-1:0]         result,
    output llsel_pkg::alu_flags_t flags
);
    import llsel_pkg::*;

    // compare side
    always_comb
    begin
        flags.below_cap = (a < CW'(LOAD_CAP));
        flags.is_zero   = (a == '0);
        flags.better    = !found || (a < b);
    end

    // add side
    always_comb
    begin
        case (op)
            OP_INC:  result = a + CW'(1);
            OP_DEC:  result = a - CW'(1);
            default: result = a;
        endcase
    end

endmodule

[design/llsel_count_mem.sv]
// llsel_count_mem: busy count store, one write and one registered read port,
// with a valid bit per entry so that entries read as zero after reset
module llsel_count_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int CW    = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [CW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [CW-1:0] wr_data
);
    logic [CW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [CW-1:0]    rd_data_reg;

    // valid bits, cleared together at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[tb/sv/llsel_grant_checker.sv]
// llsel_grant_checker: watches the input, result and register channels of the
// least loaded selector, predicts every result and compares it field by field
// depends on llsel_pkg for widths, status codes and item kinds
module llsel_grant_checker #(
    parameter int NUM_TARGETS = 8,
    parameter int LOAD_CAP    = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] target_index, rest zero
    input  logic        s_tuser,   // [0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [2:0] chosen_index, [13:3] load_after, rest zero
    input  logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding,
    output int          grants,
    output int          no_target,
    output int          releases,
    output int          bad_releases,
    output int          peak_load
);
    import llsel_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [STATUS_W-1:0] status;
        logic [LOAD_W-1:0]   load;
    } grant_t;

    // shadow of the busy counts and of the active interface register
    logic [LOAD_W-1:0] busy [NUM_TARGETS];
    logic [ACT_W-1:0]  active_cfg;
    grant_t            expected_grants[$];
    grant_t            want;
    grant_t            got;

    // apply one item to the shadow counts and return the reply it earns
    function automatic grant_t select_or_release(logic mode, logic [TARGET_W-1:0] tgt);
        int     n;
        int     best;
        logic   found;
        logic   hit_zero;
        grant_t r;
        r        = '0;
        r.status = ST_OK;
        n        = (active_cfg > NUM_TARGETS) ? NUM_TARGETS : int'(active_cfg);
        if (mode == MODE_CHOOSE)
        begin
            found    = 1'b0;
            hit_zero = 1'b0;
            best     = 0;
            // scan upward, stop at the first idle interface, skip capped ones
            for (int i = 0; i < NUM_TARGETS; i++)
            begin
                if (i < n && !hit_zero && busy[i] < LOAD_CAP)
                begin
                    if (busy[i] == 0)
                    begin
                        best     = i;
                        found    = 1'b1;
                        hit_zero = 1'b1;
                    end
                    else if (!found || busy[i] < busy[best])
                    begin
                        best  = i;
                        found = 1'b1;
                    end
                end
            end
            if (!found)
                r.status = ST_NONE;
            else
            begin
                busy[best] = busy[best] + 1'b1;
                r.idx      = best[IDX_W-1:0];
                r.load     = busy[best];
            end
        end
        else if (tgt >= n || busy[tgt] == 0)
            r.status = ST_BAD_RELEASE;
        else
        begin
            busy[tgt] = busy[tgt] - 1'b1;
            r.idx     = tgt;
            r.load    = busy[tgt];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TARGETS; i++)
                busy[i] = '0;
            active_cfg = ACT_W'(ACT_RESET);
            expected_grants.delete();
            mismatches   = 0;
            grants       = 0;
            no_target    = 0;
            releases     = 0;
            bad_releases = 0;
            peak_load    = 0;
            outstanding <= 0;
        end
        else
        begin
            // register write, only word 0 exists
            if (psel && penable && pwrite && pready && (paddr >> 2) == 0)
                active_cfg = pwdata[ACT_W-1:0];

            // predict on each input transfer
            if (s_tvalid && s_tready)
            begin
                want = select_or_release(s_tuser, s_tdata[TARGET_W-1:0]);
                expected_grants = {expected_grants, want};
                if (want.status == ST_NONE)
                    no_target++;
                else if (want.status == ST_BAD_RELEASE)
                    bad_releases++;
                else if (s_tuser == MODE_CHOOSE)
                    grants++;
                else
                    releases++;
                if (int'(want.load) > peak_load)
                    peak_load = int'(want.load);
            end

            // compare each result transfer with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.idx    = m_tdata[IDX_W-1:0];
                got.load   = m_tdata[IDX_W +: LOAD_W];
                got.status = m_tuser;
                if (expected_grants.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("mismatch: result idx=%0d status=%0d load=%0d with none pending",
                                 got.idx, got.status, got.load);
                    mismatches++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (got.idx !== want.idx || got.status !== want.status
                        || got.load !== want.load)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: exp idx=%0d st=%0d load=%0d, got %0d %0d %0d",
                                     want.idx, want.status, want.load,
                                     got.idx, got.status, got.load);
                        mismatches++;
                    end
                end
            end
            outstanding <= expected_grants.size();
        end
    end

endmodule

[tb/sv/least_loaded_selector_top_tb.sv]
// least_loaded_selector_top_tb: drives items and register writes into the
// least loaded selector and reports the verdict from llsel_grant_checker
// depends on llsel_pkg, least_loaded_selector_top and llsel_grant_checker
module least_loaded_selector_top_tb;
    import llsel_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam logic [2:0] ADDR_ACTIVE = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic [31:0] prdata;
    logic        pready;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic stall_req   = 1'b0;
    logic stall_taken = 1'b0;
    int   stall_left  = 0;
    int   cycle_count = 0;

    int mismatches;
    int outstanding;
    int grants;
    int no_target;
    int releases;
    int bad_releases;
    int peak_load;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    least_loaded_selector_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    llsel_grant_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .grants       (grants),
        .no_target    (no_target),
        .releases     (releases),
        .bad_releases (bad_releases),
        .peak_load    (peak_load)
    );

    // result side: random back-pressure plus one long hold-off on request
    always @(posedge clk)
    begin
        if (stall_req && !stall_taken)
        begin
            stall_taken <= 1'b1;
            stall_left  <= 300;
            m_tready    <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // offer one item and wait for its transfer, with an optional gap first
    task automatic offer(input logic mode, input logic [TARGET_W-1:0] tgt);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, tgt};
        do @(posedge clk); while (!s_tready);
    endtask

    // stop offering and wait until every result has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, setup then access phase
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_active(input int value);
        settle();
        write_reg(ADDR_ACTIVE, value);
    endtask

    // random mix of choose and release items over all target indices
    task automatic run_mix(input int count, input int choose_pct);
        repeat (count)
            offer(($urandom_range(99) < choose_pct) ? MODE_CHOOSE : MODE_RELEASE,
                  TARGET_W'($urandom_range(7)));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct <= 21;
        rx_idle_pct <= 47;

        // all eight interfaces active after reset
        offer(MODE_CHOOSE, 3'd0);
        offer(MODE_CHOOSE, 3'd7);      // target bits ignored on choose
        offer(MODE_RELEASE, 3'd7);     // release of an idle interface
        offer(MODE_RELEASE, 3'd1);
        offer(MODE_CHOOSE, 3'd0);      // idle interface taken at once
        offer(MODE_RELEASE, 3'd0);
        offer(MODE_RELEASE, 3'd0);     // would go below zero
        offer(MODE_CHOOSE, 3'd3);

        // three active: releases past the active set, ties go to lowest index
        set_active(3);
        offer(MODE_RELEASE, 3'd5);
        offer(MODE_RELEASE, 3'd3);
        offer(MODE_CHOOSE, 3'd0);
        offer(MODE_CHOOSE, 3'd0);
        offer(MODE_CHOOSE, 3'd0);

        // write to a register that does not exist leaves the setting alone
        settle();
        write_reg(ADDR_UNUSED, 32'd0);
        offer(MODE_RELEASE, 3'd2);

        // no active interfaces
        set_active(0);
        offer(MODE_CHOOSE, 3'd0);
        offer(MODE_RELEASE, 3'd0);

        // out-of-range setting clips to all eight
        set_active(15);
        offer(MODE_RELEASE, 3'd7);
        offer(MODE_CHOOSE, 3'd5);
        offer(MODE_CHOOSE, 3'd2);

        // one interface driven up to the cap, long result stall on the way
        set_active(1);
        for (int i = 0; i < 1060; i++)
        begin
            if (i == 200)
                stall_req <= 1'b1;
            if (i < 1040)
                offer(MODE_CHOOSE, TARGET_W'($urandom_range(7)));
            else
                offer(1'($urandom_range(1)), TARGET_W'($urandom_range(7)));
        end

        // swapped idling, capped interface now shares with others
        settle();
        tx_idle_pct <= 47;
        rx_idle_pct <= 21;
        repeat (4)
        begin
            set_active($urandom_range(2, 15));
            run_mix(50, 55);
        end

        // no idling on either side
        settle();
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        set_active(8);
        run_mix(50, 60);
        set_active($urandom_range(1, 8));
        run_mix(50, 50);
        set_active(15);
        run_mix(50, 60);

        settle();
        repeat (16) @(posedge clk);
        $display("covered %0d grants, %0d none-available, %0d releases, %0d rejected releases",
                 grants, no_target, releases, bad_releases);
        $display("peak busy count %0d; active settings 0, 1, 3, 8, 15 and random; one long stall",
                 peak_load);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
design/llsel_pkg.sv
design/llsel_alu.sv
design/llsel_count_mem.sv
design/least_loaded_selector_top.sv
tb/sv/llsel_grant_checker.sv
tb/sv/least_loaded_selector_top_tb.sv
